>>> hw/rtl/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
package lir_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int PHASE_FRAC_BITS = 32;
	localparam int STEP_W          = 37;
	localparam int ACC_W           = PHASE_FRAC_BITS + 5;
	localparam int MAX_OUT         = 16;
	localparam int CNT_W           = $clog2(MAX_OUT + 1);
	localparam int TDATA_W         = ((SAMPLE_BITS + 7) / 8) * 8;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd1 << (PHASE_FRAC_BITS - 1));
	localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(64'd1 << (PHASE_FRAC_BITS - 4));
	localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(64'd1 << (PHASE_FRAC_BITS + 4));
	localparam logic [ACC_W-1:0]  ACC_ONE    = ACC_W'(64'd1 << PHASE_FRAC_BITS);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ACC_W-1:0]              acc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_EMIT,
		ST_DONE
	} state_t;

	// request to the shared interpolation unit
	typedef struct packed {
		logic                       en;
		sample_t                    a;
		sample_t                    b;
		logic [PHASE_FRAC_BITS-1:0] frac;
	} mul_req_t;

endpackage

>>> hw/rtl/linear_interp_resampler.sv
// Top level: linear interpolation resampler with sequencer and output register.
// Each result passes through CHECK, MUL (registered multiply) and EMIT (truncate and load the
// output register once it is free); each dropped position above 16 results and each wrap pass
// through CHECK alone. An item is taken only in IDLE, so no new item is accepted while one is in
// progress; output stalls hold the sequencer in EMIT.
// Reset (arst_n low) clears the previous sample, phase and output valid; the step returns to 0.5.
module linear_interp_resampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lir_pkg::STEP_W-1:0]        cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lir_pkg::TDATA_W-1:0]       s_tdata,  // [15:0] sample
	input  logic                              s_tlast,  // block_last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lir_pkg::TDATA_W-1:0]       m_tdata,  // [15:0] out_sample
	output logic                              m_tlast   // run_last
);

	localparam int F = lir_pkg::PHASE_FRAC_BITS;

	lir_pkg::state_t             state_q, state_d;
	logic [lir_pkg::STEP_W-1:0]  cfg_step_q;
	lir_pkg::acc_t               step_q;
	lir_pkg::acc_t               acc_q;
	lir_pkg::sample_t            cur_q;
	lir_pkg::sample_t            prev_q;
	logic                        last_q;
	logic                        ph2_q;     // repeating the block's last sample
	logic                        primed_q;
	logic [lir_pkg::CNT_W-1:0]   cnt_q;
	logic                        m_tvalid_q;
	lir_pkg::sample_t            m_sample_q;
	logic                        m_last_q;

	logic                        accept;
	logic                        slot_free;
	logic                        acc_lt1;
	logic                        acc_lt2;
	logic                        cnt_full;
	logic                        more;
	logic                        load_out;
	logic [lir_pkg::STEP_W-1:0]  step_clamp;
	lir_pkg::mul_req_t           mul_req;
	lir_pkg::sample_t            mul_res;

	// configuration register, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_step_q <= lir_pkg::STEP_RESET;
		end else if (cfg_we) begin
			cfg_step_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (cfg_step_q < lir_pkg::STEP_MIN) begin
			step_clamp = lir_pkg::STEP_MIN;
		end else if (cfg_step_q > lir_pkg::STEP_MAX) begin
			step_clamp = lir_pkg::STEP_MAX;
		end else begin
			step_clamp = cfg_step_q;
		end
	end

	assign acc_lt1   = (acc_q[lir_pkg::ACC_W-1:F] == '0);
	assign acc_lt2   = (acc_q[lir_pkg::ACC_W-1:F+1] == '0);
	assign cnt_full  = (cnt_q == lir_pkg::CNT_W'(lir_pkg::MAX_OUT));
	assign slot_free = !m_tvalid_q || m_tready;
	// does another emitted position follow the one in flight (acc already advanced)
	assign more      = acc_lt1 || (!ph2_q && last_q && acc_lt2);

	assign mul_req.en   = (state_q == lir_pkg::ST_MUL);
	assign mul_req.a    = ph2_q ? cur_q : prev_q;
	assign mul_req.b    = cur_q;
	assign mul_req.frac = acc_q[F-1:0];

	lir_interp u_interp (
		.clk    (clk),
		.req    (mul_req),
		.result (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lir_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			lir_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept = 1'b1;
					// an unprimed, non-final sample only primes the pair
					state_d = (primed_q || s_tlast) ? lir_pkg::ST_CHECK : lir_pkg::ST_DONE;
				end
			end
			lir_pkg::ST_CHECK: begin
				if (acc_lt1) begin
					if (!cnt_full) begin
						state_d = lir_pkg::ST_MUL;
					end
				end else if (ph2_q || !last_q) begin
					state_d = lir_pkg::ST_DONE;
				end
			end
			lir_pkg::ST_MUL: begin
				state_d = lir_pkg::ST_EMIT;
			end
			lir_pkg::ST_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = lir_pkg::ST_CHECK;
				end
			end
			lir_pkg::ST_DONE: begin
				state_d = lir_pkg::ST_IDLE;
			end
			default: begin
				state_d = lir_pkg::ST_IDLE;
			end
		endcase
	end

	// phase, pair and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			prev_q   <= '0;
			primed_q <= 1'b0;
			ph2_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				lir_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						ph2_q <= !primed_q;
						if (!primed_q) begin
							acc_q <= '0;
						end
					end
				end
				lir_pkg::ST_CHECK: begin
					if (acc_lt1) begin
						if (cnt_full) begin
							acc_q <= acc_q + step_q;   // dropped position
						end
					end else if (!ph2_q) begin
						acc_q <= acc_q - lir_pkg::ACC_ONE;
						if (last_q) begin
							ph2_q <= 1'b1;
						end
					end
				end
				lir_pkg::ST_MUL: begin
					acc_q <= acc_q + step_q;
				end
				lir_pkg::ST_EMIT: begin
					if (load_out) begin
						cnt_q <= cnt_q + lir_pkg::CNT_W'(1);
					end
				end
				lir_pkg::ST_DONE: begin
					prev_q <= cur_q;
					if (last_q) begin
						acc_q    <= '0;
						primed_q <= 1'b0;
					end else begin
						acc_q    <= {1'b0, acc_q[lir_pkg::ACC_W-2:0]};
						primed_q <= 1'b1;
					end
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= s_tdata[lir_pkg::SAMPLE_BITS-1:0];
			last_q <= s_tlast;
			step_q <= lir_pkg::ACC_W'(step_clamp);
		end
	end

	// output register parts the sequencer from the downstream stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_sample_q <= mul_res;
			m_last_q   <= !more || (cnt_q == lir_pkg::CNT_W'(lir_pkg::MAX_OUT - 1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = lir_pkg::TDATA_W'({1'b0, m_sample_q});
	assign m_tlast  = m_last_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lir_pkg::CNT_W'(lir_pkg::MAX_OUT))
		else $error("result count beyond limit");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lir_pkg::ST_IDLE) |->
		(step_q >= lir_pkg::ACC_W'(lir_pkg::STEP_MIN)) &&
		(step_q <= lir_pkg::ACC_W'(lir_pkg::STEP_MAX)))
		else $error("step outside clamp range");

	a_cap_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && cnt_q == lir_pkg::CNT_W'(lir_pkg::MAX_OUT - 1)) |=> m_tlast)
		else $error("sixteenth result not marked last");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready while item in progress");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> slot_free)
		else $error("output register overwritten");

endmodule

>>> hw/rtl/lir_interp.sv
// Shared interpolation unit: registered multiply, then truncation toward zero.
module lir_interp (
	input  logic              clk,
	input  lir_pkg::mul_req_t req,
	output lir_pkg::sample_t  result
);

	localparam int PW = lir_pkg::SAMPLE_BITS + lir_pkg::PHASE_FRAC_BITS + 2;
	localparam int HW = lir_pkg::SAMPLE_BITS + 2;
	localparam int SW = lir_pkg::SAMPLE_BITS + 3;

	logic signed [lir_pkg::SAMPLE_BITS:0] diff_c;
	logic signed [PW-1:0]                 prod_c;
	logic signed [PW-1:0]                 prod_s1;
	lir_pkg::sample_t                     a_s1;
	logic signed [HW-1:0]                 prod_hi;
	logic signed [SW-1:0]                 sum_c;
	logic signed [SW-1:0]                 res_c;
	logic                                 lo_nz;
	logic                                 corr;

	assign diff_c = $signed({req.b[lir_pkg::SAMPLE_BITS-1], req.b})
		- $signed({req.a[lir_pkg::SAMPLE_BITS-1], req.a});
	assign prod_c = diff_c * $signed({1'b0, req.frac});

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_s1 <= prod_c;
			a_s1    <= req.a;
		end
	end

	// v = a*2^F + prod; floor of v is a + prod_hi, pull negatives up when bits drop
	assign prod_hi = prod_s1[PW-1:lir_pkg::PHASE_FRAC_BITS];
	assign lo_nz   = |prod_s1[lir_pkg::PHASE_FRAC_BITS-1:0];
	assign sum_c   = $signed({{2{a_s1[lir_pkg::SAMPLE_BITS-1]}}, a_s1})
		+ $signed({prod_hi[HW-1], prod_hi});
	assign corr    = sum_c[SW-1] & lo_nz;
	assign res_c   = sum_c + $signed({{(SW-1){1'b0}}, corr});
	assign result  = res_c[lir_pkg::SAMPLE_BITS-1:0];

endmodule
